>>> src/median_of_loaded_set_defines.svh
// Assertion macros shared by the median block RTL.
`ifndef MEDIAN_OF_LOADED_SET_DEFINES_SVH
`define MEDIAN_OF_LOADED_SET_DEFINES_SVH

// Implication in the same cycle.
`define MOL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define MOL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/mol_pkg.sv
// Shared types and constants for the median block.
`timescale 1ns / 1ps
package mol_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic     ins;
      logic     shift;
      data_type din;
   } cell_ctrl_type;

endpackage

>>> src/mol_cell.sv
// One sort cell: compare against the broadcast value, insert or shift.
`timescale 1ns / 1ps
module mol_cell
   import mol_pkg::*;
#(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [CNT_W-1:0] count,
   input  data_type         left_val,
   input  logic             left_gt,
   input  data_type         right_val,
   output data_type         val,
   output logic             gt
);

   data_type val_ff;
   data_type val_in;
   logic     occupied;

   assign occupied = count > CNT_W'(INDEX);
   // empty cells act as +infinity, so a new maximum goes to the first free slot
   assign gt       = !occupied || (val_ff > ctrl.din);
   assign val      = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.ins && gt) begin
         val_in = left_gt ? left_val : ctrl.din;
      end else if (ctrl.shift) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

>>> src/median_of_loaded_set.sv
// Median of a loaded set: a chain of sort cells plus readout control.
// Usage:
//   req_* carries one item per handshake: req_value (signed Q23.8),
//   req_value_present and req_last. Present values are inserted into a
//   sorted chain of MAX_VALUES cells, one item per cycle while loading.
//   Values beyond MAX_VALUES are dropped and flagged as overflow.
//   On the item with req_last the chain is shifted toward cell 0 until the
//   middle item reaches cell 0 for an odd count, or the middle pair reaches
//   cells 0 and 1 for an even count; an empty set is not shifted. Then the
//   result is registered on rsp_*: rsp_median, rsp_empty_error, rsp_overflow.
//   req_ready is low while shifting.
//   The set counter clears with the last item, so the next set may load
//   while the result waits in the output register. A stalled receiver
//   holds the result; a new result is not produced until it is taken, and
//   req_ready stays low after the next last item until then.
//   Reset (synchronous) empties the set and drops any pending result.
`timescale 1ns / 1ps
`include "median_of_loaded_set_defines.svh"
module median_of_loaded_set
   import mol_pkg::*;
#(
   parameter int MAX_VALUES = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  data_type req_value,
   input  logic     req_value_present,
   input  logic     req_last,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output data_type rsp_median,
   output logic     rsp_empty_error,
   output logic     rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_VALUES + 1);
   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_SHIFT = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic             pend_empty_ff, pend_empty_in;
   logic             pend_ovf_ff, pend_ovf_in;
   logic             pend_even_ff, pend_even_in;
   logic             rsp_valid_ff, rsp_valid_in;
   data_type         rsp_median_ff, rsp_median_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             req_fire;
   logic             room;
   logic             do_ins;
   logic             drop;
   logic [CNT_W-1:0] n_after;
   logic [CNT_W-1:0] half;
   logic             emit;
   logic [DATA_W:0]  pair_sum;
   cell_ctrl_type    ctrl;
   data_type         vals [MAX_VALUES];
   logic             gts  [MAX_VALUES];

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign room      = (count_ff != CNT_W'(MAX_VALUES));
   assign do_ins    = req_fire && req_value_present && room;
   assign drop      = req_fire && req_value_present && !room;
   assign n_after   = count_ff + CNT_W'(do_ins);
   assign half      = n_after >> 1;
   assign emit      = (state_ff == ST_SHIFT) && (steps_ff == '0)
                      && (!rsp_valid_ff || rsp_ready);
   assign pair_sum  = {vals[0][DATA_W-1], vals[0]} + {vals[1][DATA_W-1], vals[1]};

   assign ctrl.ins   = do_ins;
   assign ctrl.shift = (state_ff == ST_SHIFT) && (steps_ff != '0);
   assign ctrl.din   = req_value;

   for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
      data_type left_v, right_v;
      logic     left_g;
      if (i == 0) begin : g_head
         assign left_v = '0;
         assign left_g = 1'b0;
      end else begin : g_body
         assign left_v = vals[i-1];
         assign left_g = gts[i-1];
      end
      if (i == MAX_VALUES - 1) begin : g_tail
         assign right_v = vals[i];
      end else begin : g_mid
         assign right_v = vals[i+1];
      end
      mol_cell #(
         .CNT_W(CNT_W),
         .INDEX(i)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .count    (count_ff),
         .left_val (left_v),
         .left_gt  (left_g),
         .right_val(right_v),
         .val      (vals[i]),
         .gt       (gts[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = n_after;
      ovf_in        = ovf_ff || drop;
      steps_in      = steps_ff;
      pend_empty_in = pend_empty_ff;
      pend_ovf_in   = pend_ovf_ff;
      pend_even_in  = pend_even_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_median_in = rsp_median_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_last) begin
               state_in      = ST_SHIFT;
               count_in      = '0;
               ovf_in        = 1'b0;
               pend_empty_in = (n_after == '0);
               pend_ovf_in   = ovf_ff || drop;
               pend_even_in  = !n_after[0];
               if (n_after[0] || (n_after == '0)) begin
                  steps_in = half;
               end else begin
                  steps_in = half - CNT_W'(1);
               end
            end
         end
         ST_SHIFT: begin
            if (steps_ff != '0) begin
               steps_in = steps_ff - CNT_W'(1);
            end else if (emit) begin
               state_in      = ST_LOAD;
               rsp_valid_in  = 1'b1;
               rsp_empty_in  = pend_empty_ff;
               rsp_ovf_in    = pend_ovf_ff;
               if (pend_empty_ff) begin
                  rsp_median_in = '0;
               end else if (pend_even_ff) begin
                  rsp_median_in = pair_sum[DATA_W:1];
               end else begin
                  rsp_median_in = vals[0];
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_empty_ff <= pend_empty_in;
      pend_ovf_ff   <= pend_ovf_in;
      pend_even_ff  <= pend_even_in;
      rsp_median_ff <= rsp_median_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_median      = rsp_median_ff;
   assign rsp_empty_error = rsp_empty_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   `MOL_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_VALUES),
      "set count beyond capacity")
   `MOL_ASSERT_NEXT(a_last_clears, clock, reset, req_fire && req_last,
      (state_ff == ST_SHIFT) && (count_ff == '0) && !ovf_ff,
      "last item did not start readout and clear the set")
   `MOL_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid && rsp_empty_error,
      rsp_median == '0, "empty set result has nonzero median")
   `MOL_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_median), "stalled result changed")

endmodule

>>> tb/tb_median_of_loaded_set.sv
// Testbench for median_of_loaded_set: sorted-insert median checked against a queue-based model.
`timescale 1ns / 1ps
module tb_median_of_loaded_set;
   import mol_pkg::*;

   localparam int MAX_VALUES  = 64;
   localparam int LONG_HOLD   = 400;
   localparam int STUCK_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 240;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      data_type median;
      logic     empty_error;
      logic     overflow;
   } median_result_type;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_EVERY_THIRD, READY_MOSTLY} ready_mode_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   data_type req_value = '0;
   logic     req_value_present = 1'b0;
   logic     req_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   data_type rsp_median;
   logic     rsp_empty_error;
   logic     rsp_overflow;

   data_type          held_values[$];
   logic              held_overflow = 1'b0;
   median_result_type expected_medians[$];
   int unsigned       mismatch_count = 0;
   int unsigned       stuck_cycles = 0;
   int                burst_left = 0;
   bit                gaps_on = 1'b1;
   bit                hold_request = 1'b0;

   median_of_loaded_set #(.MAX_VALUES(MAX_VALUES)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .req_value_present(req_value_present),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_median(rsp_median),
      .rsp_empty_error(rsp_empty_error),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Sorted insert of one item; on last, the median of what is held.
   function automatic void predict_median(data_type v, logic present, logic last);
      int pos;
      int n;
      median_result_type r;
      logic [32:0] pair_sum;
      if (present) begin
         if (held_values.size() < MAX_VALUES) begin
            pos = held_values.size();
            while (pos > 0 && held_values[pos-1] > v) pos--;
            held_values.insert(pos, v);
         end else begin
            held_overflow = 1'b1;
         end
      end
      if (last) begin
         n = held_values.size();
         r.median = '0;
         r.empty_error = (n == 0);
         r.overflow = held_overflow;
         if (n % 2 == 1) begin
            r.median = held_values[n/2];
         end else if (n > 0) begin
            pair_sum = {held_values[n/2-1][DATA_W-1], held_values[n/2-1]} +
                       {held_values[n/2][DATA_W-1], held_values[n/2]};
            r.median = pair_sum[32:1];
         end
         expected_medians.insert(expected_medians.size(), r);
         held_values.delete();
         held_overflow = 1'b0;
      end
   endfunction

   function automatic data_type rand_sample();
      data_type v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh7fffffff;
               1: v = 32'sh80000000;
               2: v = '0;
               default: v = -32'sd1;
            endcase
         end
         1, 2, 3: v = data_type'($urandom_range(0, 31)) - 32'sd16;
         default: v = data_type'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_item(input data_type v, input logic present, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 12) : 0;
         burst_left = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_value <= data_type'($urandom);
            req_value_present <= $urandom_range(0, 1);
            req_last <= $urandom_range(0, 1);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_value <= v;
      req_value_present <= present;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      predict_median(v, present, last);
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_all_results();
      idle_req();
      while (expected_medians.size() != 0) @(posedge clock);
   endtask

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(data_type'($urandom), 1'b0, 1'b0);
         send_item(rand_sample(), 1'b1, (i == n - 1) && ($urandom_range(0, 4) != 0));
      end
      if (n == 0 || !req_last) send_item(data_type'($urandom), 1'b0, 1'b1);
   endtask

   task automatic test_directed();
      send_item(32'sh7fffffff, 1'b0, 1'b1);
      send_item(32'sh7fffffff, 1'b1, 1'b1);
      send_item(32'sh80000000, 1'b1, 1'b1);
      send_item(32'sh7fffffff, 1'b1, 1'b0);
      send_item(32'sh7fffffff, 1'b1, 1'b1);
      send_item(32'sh80000000, 1'b1, 1'b0);
      send_item(32'sh80000000, 1'b1, 1'b1);
      send_item(32'sh80000000, 1'b1, 1'b0);
      send_item(32'sh7fffffff, 1'b1, 1'b1);
      send_item(-32'sd1, 1'b1, 1'b0);
      send_item(32'sd0, 1'b1, 1'b1);
      send_item(32'sd5, 1'b1, 1'b0);
      send_item(32'sh80000000, 1'b0, 1'b0);
      send_item(-32'sd3, 1'b1, 1'b0);
      send_item(32'sd100, 1'b0, 1'b0);
      send_item(32'sd9, 1'b1, 1'b1);
      send_item(32'sd10, 1'b1, 1'b0);
      send_item(32'sd20, 1'b1, 1'b0);
      send_item(32'sh55555555, 1'b0, 1'b1);
      send_item(32'sd7, 1'b1, 1'b0);
      send_item(32'sd7, 1'b1, 1'b0);
      send_item(32'sd3, 1'b1, 1'b0);
      send_item(32'sd3, 1'b1, 1'b1);
   endtask

   // Exactly full store, then past capacity with the set closed by an empty item.
   task automatic test_full_store();
      for (int i = 0; i < MAX_VALUES; i++)
         send_item(data_type'(1000 - 37 * i), 1'b1, i == MAX_VALUES - 1);
      for (int i = 0; i < MAX_VALUES + 2; i++)
         send_item(rand_sample(), 1'b1, 1'b0);
      send_item(data_type'($urandom), 1'b0, 1'b1);
   endtask

   // Receiver holds off while the sender keeps offering short sets.
   task automatic test_output_hold();
      gaps_on = 1'b0;
      hold_request = 1'b1;
      for (int s = 0; s < 10; s++) send_set($urandom_range(1, 3));
      gaps_on = 1'b1;
   endtask

   task automatic test_random();
      int counted;
      int n;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 32))
            0: n = 0;
            1, 2: n = $urandom_range(MAX_VALUES - 4, MAX_VALUES + 6);
            default: n = $urandom_range(1, 8);
         endcase
         send_set(n);
         counted += (n == 0) ? 1 : n;
      end
   endtask

   initial begin : rsp_ready_pattern
      ready_mode_type mode;
      int mode_left;
      int hold_left;
      mode = READY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request) hold_left = LONG_HOLD;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
            if (hold_left == 0) hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               READY_ALWAYS:      rsp_ready <= 1'b1;
               READY_RANDOM:      rsp_ready <= ($urandom_range(0, 9) > 3);
               READY_EVERY_THIRD: rsp_ready <= (mode_left % 3 == 0);
               default:           rsp_ready <= ($urandom_range(0, 9) > 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      median_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_medians.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: unexpected item median=%0d empty=%0b overflow=%0b",
                        $realtime, rsp_median, rsp_empty_error, rsp_overflow);
            mismatch_count++;
         end else begin
            want = expected_medians.pop_front();
            if (rsp_median !== want.median || rsp_empty_error !== want.empty_error ||
                rsp_overflow !== want.overflow) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: median exp %0d/%0b/%0b got %0d/%0b/%0b", $realtime,
                           want.median, want.empty_error, want.overflow,
                           rsp_median, rsp_empty_error, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin : watchdog
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("tb_median_of_loaded_set failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      wait_for_all_results();
      test_full_store();
      test_output_hold();
      wait_for_all_results();
      test_random();
      wait_for_all_results();
      repeat (MAX_VALUES / 2 + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_median_of_loaded_set passed");
      else
         $display("tb_median_of_loaded_set failed");
      $finish;
   end

endmodule
